// ===== hw/rtl/aob_pkg.sv =====
// Shared types and constants for the alpha-over RGBA8 blender.
package aob_pkg;

    // Field widths fixed by the pixel and coordinate formats
    localparam int CH_W    = 8;
    localparam int COORD_W = 14;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 24;
    localparam int NCH     = 3;

    // Configuration register indexes
    localparam int          CFG_IDX_W         = 2;
    localparam logic [1:0]  REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0]  REG_CANVAS_HEIGHT = 2'd1;

    localparam logic [12:0] CANVAS_WIDTH_RST  = 13'd1024;
    localparam logic [12:0] CANVAS_HEIGHT_RST = 13'd768;

    // Full-scale alpha
    localparam logic [7:0]  ALPHA_MAX = 8'd255;

    // x / 255 as (x * RECIP_255) >> RECIP_SH, exact for x < 16909320
    localparam logic [24:0] RECIP_255 = 25'd16843010;
    localparam int          RECIP_SH  = 32;

    // Side information carried alongside the colour arithmetic
    typedef struct packed {
        logic               inb;
        logic [IDX_W-1:0]   idx;
    } side_t;

endpackage

// ===== hw/rtl/alpha_over_blend_rgba.sv =====
// Alpha-over blender: straight-alpha RGBA8 source over destination, one pixel per unstalled clock.
//
// Each beat carries a source pixel, the destination pixel under it and its
// signed canvas position; each result beat carries the blended pixel, its
// linear canvas index and a write enable. The block accepts one pixel every
// clock while no backpressure stalls it and returns each result in order.
// Nine register stages: three multiply stages (products, exact
// divide-by-255 via reciprocal products), one stage forming the colour
// numerators and the overflow check, four stages of restoring division
// that resolve two quotient bits each, and the output register.
// Backpressure from m_tready runs back through a per-stage ready chain,
// so empty stages are filled while the output waits. Canvas size registers
// are written through the cfg port and must only change while idle.
module alpha_over_blend_rgba #(
    parameter int MAX_CANVAS_DIM = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    // dest_x[13:0], dest_y[27:14], src_red[35:28], src_green[43:36],
    // src_blue[51:44], src_opacity[59:52], dst_red[67:60], dst_green[75:68],
    // dst_blue[83:76], dst_alpha[91:84], zero pad[95:92]
    input  logic [95:0] s_tdata,
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16],
    // out_alpha_value[31:24], canvas_index[55:32]
    output logic [55:0] m_tdata,
    // write_enable[0]
    output logic [0:0]  m_tuser
);

    localparam int DIM_W  = $clog2(MAX_CANVAS_DIM + 1);
    localparam int EW     = (DIM_W > aob_pkg::CFG_W) ? DIM_W : aob_pkg::CFG_W;
    localparam int PROD_W = 13 + EW;
    localparam int NSTG   = 9;
    localparam int NDIV   = 4;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [12:0] cw_reg, ch_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= aob_pkg::CANVAS_WIDTH_RST;
            ch_reg <= aob_pkg::CANVAS_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                aob_pkg::REG_CANVAS_WIDTH:  cw_reg <= cfg_data;
                aob_pkg::REG_CANVAS_HEIGHT: ch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective dimensions, limited to the largest canvas
    logic [EW-1:0] w_eff, h_eff;
    assign w_eff = (EW'(cw_reg) > EW'(MAX_CANVAS_DIM)) ? EW'(MAX_CANVAS_DIM) : EW'(cw_reg);
    assign h_eff = (EW'(ch_reg) > EW'(MAX_CANVAS_DIM)) ? EW'(MAX_CANVAS_DIM) : EW'(ch_reg);

    // ---------------------------------------------------------------
    // Input field unpacking
    // ---------------------------------------------------------------
    logic [13:0]                 in_x, in_y;
    logic [7:0]                  in_sa, in_da;
    logic [aob_pkg::NCH-1:0][7:0] in_sc, in_dc;

    assign in_x     = s_tdata[13:0];
    assign in_y     = s_tdata[27:14];
    assign in_sc[0] = s_tdata[35:28];
    assign in_sc[1] = s_tdata[43:36];
    assign in_sc[2] = s_tdata[51:44];
    assign in_sa    = s_tdata[59:52];
    assign in_dc[0] = s_tdata[67:60];
    assign in_dc[1] = s_tdata[75:68];
    assign in_dc[2] = s_tdata[83:76];
    assign in_da    = s_tdata[91:84];

    // ---------------------------------------------------------------
    // Pipeline control: valid per stage, ready chain from the output
    // ---------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: bounds check, row product, 8x8 products
    // ---------------------------------------------------------------
    logic                          s1_inb_reg;
    logic [aob_pkg::IDX_W-1:0]     s1_rowp_reg;
    logic [12:0]                   s1_x_reg;
    logic [7:0]                    s1_sa_reg, s1_inv_sa_reg;
    logic [15:0]                   s1_pda_reg;
    logic [aob_pkg::NCH-1:0][15:0] s1_scsa_reg, s1_dcda_reg;

    logic          inb_next;
    logic [7:0]    inv_sa_next;
    logic [PROD_W-1:0] rowp_next;

    assign inb_next = !in_x[13] && !in_y[13]
                   && (EW'(in_x[12:0]) < w_eff) && (EW'(in_y[12:0]) < h_eff);
    assign inv_sa_next = aob_pkg::ALPHA_MAX - in_sa;
    assign rowp_next   = PROD_W'(in_y[12:0]) * PROD_W'(w_eff);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_inb_reg    <= inb_next;
            s1_rowp_reg   <= rowp_next[aob_pkg::IDX_W-1:0];
            s1_x_reg      <= in_x[12:0];
            s1_sa_reg     <= in_sa;
            s1_inv_sa_reg <= inv_sa_next;
            s1_pda_reg    <= 16'(in_da) * 16'(inv_sa_next);
            for (int c = 0; c < aob_pkg::NCH; c++) begin
                s1_scsa_reg[c] <= 16'(in_sc[c]) * 16'(in_sa);
                s1_dcda_reg[c] <= 16'(in_dc[c]) * 16'(in_da);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: index sum, alpha term / 255, colour term times (255 - sa)
    // ---------------------------------------------------------------
    aob_pkg::side_t                s2_side_reg;
    logic [7:0]                    s2_sa_reg, s2_qda_reg;
    logic [aob_pkg::NCH-1:0][15:0] s2_scsa_reg;
    logic [aob_pkg::NCH-1:0][23:0] s2_t_reg;

    logic [40:0] qda_prod;
    assign qda_prod = 41'(s1_pda_reg) * 41'(aob_pkg::RECIP_255);

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_side_reg.inb <= s1_inb_reg;
            s2_side_reg.idx <= s1_inb_reg ?
                               (s1_rowp_reg + aob_pkg::IDX_W'(s1_x_reg)) : '0;
            s2_sa_reg       <= s1_sa_reg;
            s2_qda_reg      <= qda_prod[aob_pkg::RECIP_SH +: 8];
            s2_scsa_reg     <= s1_scsa_reg;
            for (int c = 0; c < aob_pkg::NCH; c++) begin
                s2_t_reg[c] <= 24'(s1_dcda_reg[c]) * 24'(s1_inv_sa_reg);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: blended alpha, colour term / 255
    // ---------------------------------------------------------------
    aob_pkg::side_t                s3_side_reg;
    logic [7:0]                    s3_oa_reg;
    logic [aob_pkg::NCH-1:0][15:0] s3_scsa_reg, s3_tq_reg;

    logic [aob_pkg::NCH-1:0][48:0] tq_prod;
    logic [8:0]                    oa_sum;

    always_comb begin
        for (int c = 0; c < aob_pkg::NCH; c++) begin
            tq_prod[c] = 49'(s2_t_reg[c]) * 49'(aob_pkg::RECIP_255);
        end
    end
    assign oa_sum = 9'(s2_sa_reg) + 9'(s2_qda_reg);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_side_reg <= s2_side_reg;
            s3_oa_reg   <= oa_sum[7:0];
            s3_scsa_reg <= s2_scsa_reg;
            for (int c = 0; c < aob_pkg::NCH; c++) begin
                s3_tq_reg[c] <= tq_prod[c][aob_pkg::RECIP_SH +: 16];
            end
        end
    end

    // ---------------------------------------------------------------
    // Divider stages: entry 0 holds numerator and overflow flag,
    // entries 1..4 each resolve two quotient bits
    // ---------------------------------------------------------------
    aob_pkg::side_t                dv_side_reg [NDIV+1];
    logic [7:0]                    dv_oa_reg   [NDIV+1];
    logic [aob_pkg::NCH-1:0][16:0] dv_rem_reg  [NDIV+1];
    logic [aob_pkg::NCH-1:0][7:0]  dv_q_reg    [NDIV+1];
    logic [aob_pkg::NCH-1:0]       dv_over_reg [NDIV+1];

    logic [aob_pkg::NCH-1:0][16:0] dv_rem_next [NDIV+1];
    logic [aob_pkg::NCH-1:0][7:0]  dv_q_next   [NDIV+1];
    logic [aob_pkg::NCH-1:0]       dv_over_next;

    always_comb begin : div_steps
        logic [16:0] rem_t;
        logic [16:0] dsr;
        logic [7:0]  q_t;
        // numerator and clamp detection
        for (int c = 0; c < aob_pkg::NCH; c++) begin
            dv_rem_next[0][c] = 17'(s3_scsa_reg[c]) + 17'(s3_tq_reg[c]);
            dv_q_next[0][c]   = '0;
            dv_over_next[c]   = dv_rem_next[0][c] >= 17'({s3_oa_reg, 8'h00});
        end
        // two restoring steps per stage, quotient MSB first
        for (int j = 1; j <= NDIV; j++) begin
            for (int c = 0; c < aob_pkg::NCH; c++) begin
                rem_t = dv_rem_reg[j-1][c];
                q_t   = dv_q_reg[j-1][c];
                for (int b = 0; b < 2; b++) begin
                    dsr = 17'(dv_oa_reg[j-1]) << (9 - 2 * j - b);
                    if (rem_t >= dsr) begin
                        rem_t = rem_t - dsr;
                        q_t[9 - 2 * j - b] = 1'b1;
                    end
                end
                dv_rem_next[j][c] = rem_t;
                dv_q_next[j][c]   = q_t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            dv_side_reg[0] <= s3_side_reg;
            dv_oa_reg[0]   <= s3_oa_reg;
            dv_rem_reg[0]  <= dv_rem_next[0];
            dv_q_reg[0]    <= dv_q_next[0];
            dv_over_reg[0] <= dv_over_next;
        end
        for (int j = 1; j <= NDIV; j++) begin
            if (en[3+j]) begin
                dv_side_reg[j] <= dv_side_reg[j-1];
                dv_oa_reg[j]   <= dv_oa_reg[j-1];
                dv_rem_reg[j]  <= dv_rem_next[j];
                dv_q_reg[j]    <= dv_q_next[j];
                dv_over_reg[j] <= dv_over_reg[j-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: clamp, zero off-canvas and transparent pixels
    // ---------------------------------------------------------------
    logic [aob_pkg::NCH-1:0][7:0] out_c_reg;
    logic [7:0]                   out_a_reg;
    logic [aob_pkg::IDX_W-1:0]    out_idx_reg;
    logic                         out_we_reg;

    logic we_next;
    assign we_next = dv_side_reg[NDIV].inb && (dv_oa_reg[NDIV] != 8'd0);

    always_ff @(posedge aclk) begin
        if (en[NSTG-1]) begin
            for (int c = 0; c < aob_pkg::NCH; c++) begin
                out_c_reg[c] <= !we_next ? 8'd0 :
                                dv_over_reg[NDIV][c] ? aob_pkg::ALPHA_MAX :
                                dv_q_reg[NDIV][c];
            end
            out_a_reg   <= dv_side_reg[NDIV].inb ? dv_oa_reg[NDIV] : 8'd0;
            out_idx_reg <= dv_side_reg[NDIV].idx;
            out_we_reg  <= we_next;
        end
    end

    assign m_tdata = {out_idx_reg, out_a_reg, out_c_reg[2], out_c_reg[1], out_c_reg[0]};
    assign m_tuser = out_we_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // an empty output stage means every stage can move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // a write enable always carries a nonzero blended alpha
    a_we_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[31:24] != 8'd0))
        else $error("write enable with zero alpha");

    // unclamped division leaves a remainder below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[3+NDIV] && dv_oa_reg[NDIV] != 8'd0) |->
        ((dv_over_reg[NDIV][0] || dv_rem_reg[NDIV][0] < 17'(dv_oa_reg[NDIV])) &&
         (dv_over_reg[NDIV][1] || dv_rem_reg[NDIV][1] < 17'(dv_oa_reg[NDIV])) &&
         (dv_over_reg[NDIV][2] || dv_rem_reg[NDIV][2] < 17'(dv_oa_reg[NDIV]))))
        else $error("divider remainder out of range");

endmodule
